FILE: rtl/wpcs_pkg.sv
// Shared types, codes and defaults for the worker-packing CPU selector.
package wpcs_pkg;

  // Default sizes for the counter bank.
  localparam int DEF_NUM_CPUS   = 8;
  localparam int DEF_COUNT_BITS = 8;

  // The CPU masks and the CPU field cover eight CPUs.
  localparam int MASK_CPUS = 8;
  localparam int CPU_W     = 3;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STRATEGY     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIDDLE_START = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MIDDLE_GROUP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_AVAILABLE    = 3'd4;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    FUNC_ENQ   = 2'd0,
    FUNC_DEQ   = 2'd1,
    FUNC_FIND  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_PICK,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/worker_packing_cpu_selector_core.sv
// Worker-packing CPU selector: per-CPU worker counters and middle-group CPU pick.
// Enqueue, dequeue, clear and an early-exit find pass from the input transfer through the
// execute and done states to the output register. A scanning find reads one counter a
// cycle, min(NUM_CPUS, 8) in all, through the shared read port, then picks a CPU. The next
// input transfer waits until the result is handed off; a stalled output holds it back.
// Synchronous reset clears all counters and loads the register defaults.
module worker_packing_cpu_selector_core #(
  parameter int NUM_CPUS   = wpcs_pkg::DEF_NUM_CPUS,
  parameter int COUNT_BITS = wpcs_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [2:0] cpu, [3] is_worker, [4] task_queued
  input  logic [1:0]                      s_tuser,   // [1:0] func
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [2:0] chosen_cpu, [3] task_queued_out,
                                                     // [4] count_error
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [wpcs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wpcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wpcs_pkg::*;

  localparam int IDX_W  = $clog2(NUM_CPUS);
  localparam int SCAN_N = (NUM_CPUS < MASK_CPUS) ? NUM_CPUS : MASK_CPUS;
  localparam logic [IDX_W-1:0]      SCAN_LAST = IDX_W'(SCAN_N - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic                  cfg_enable;
  logic                  cfg_strategy;
  logic [3:0]            cfg_start;
  logic [MASK_CPUS-1:0]  cfg_group;
  logic [MASK_CPUS-1:0]  cfg_avail;

  // Item held during its processing.
  func_t                 it_func;
  logic [CPU_W-1:0]      it_cpu;
  logic                  it_worker;
  logic                  it_queued;

  // Counter bank.
  logic [COUNT_BITS-1:0] worker_count [NUM_CPUS];

  // Sequencer and scan state.
  state_t                state, state_next;
  logic [IDX_W-1:0]      idx;
  logic                  found;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [CPU_W-1:0]      best_cpu;

  // Result and output registers.
  logic [CPU_W-1:0]      res_cpu, res_cpu_next;
  logic                  res_queued, res_queued_next;
  logic                  res_err, res_err_next;
  logic [CPU_W-1:0]      out_cpu;
  logic                  out_queued;
  logic                  out_err;

  // Control from the sequencer.
  logic                  cnt_we;
  logic                  clear_all;
  logic                  scan_start;
  logic                  scan_step;
  logic                  res_load;
  logic                  out_load;

  // Datapath signals.
  logic                  in_accept;
  logic                  it_in_range;
  logic [IDX_W-1:0]      it_idx;
  logic [4:0]            scan_ext;
  logic [CPU_W-1:0]      scan_cpu;
  logic                  scan_cand;
  logic                  start_ok;
  logic                  scan_go;
  logic [IDX_W-1:0]      rd_idx;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] cnt_step;
  logic                  at_limit;
  logic                  cnt_greater;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_enable   <= 1'b1;
      cfg_strategy <= 1'b1;
      cfg_start    <= 4'hF;
      cfg_group    <= '0;
      cfg_avail    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENABLE:       cfg_enable   <= cfg_wdata[0];
        REG_STRATEGY:     cfg_strategy <= cfg_wdata[0];
        REG_MIDDLE_START: cfg_start    <= cfg_wdata[3:0];
        REG_MIDDLE_GROUP: cfg_group    <= cfg_wdata[MASK_CPUS-1:0];
        REG_AVAILABLE:    cfg_avail    <= cfg_wdata[MASK_CPUS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item on its input transfer.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_func   <= func_t'(s_tuser);
      it_cpu    <= s_tdata[2:0];
      it_worker <= s_tdata[3];
      it_queued <= s_tdata[4];
    end
  end

  // Index and range decode for the item's CPU and the scan position.
  assign it_in_range = (32'(it_cpu) < NUM_CPUS);
  assign it_idx      = IDX_W'(it_cpu);
  assign scan_ext    = 5'(idx);
  assign scan_cpu    = scan_ext[2:0];
  assign scan_cand   = cfg_group[scan_cpu] && cfg_avail[scan_cpu];

  // The middle start CPU must be non-negative and name an existing CPU.
  assign start_ok = !cfg_start[3] && (32'(cfg_start[2:0]) < NUM_CPUS);
  assign scan_go  = it_worker && cfg_enable && cfg_strategy && start_ok && (cfg_group != '0);

  // Single counter read port, shared by the update and the scan.
  assign rd_idx = (state == ST_SCAN) ? idx : it_idx;
  assign rd_cnt = worker_count[rd_idx];

  // Shared arithmetic unit: step the count, detect saturation, compare for the scan.
  assign cnt_step    = (it_func == FUNC_ENQ) ? rd_cnt + 1'b1 : rd_cnt - 1'b1;
  assign at_limit    = (it_func == FUNC_ENQ) ? (rd_cnt == COUNT_MAX) : (rd_cnt == '0);
  assign cnt_greater = (rd_cnt > best_cnt);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: state_next = scan_start ? ST_SCAN : ST_DONE;
      ST_SCAN: if (idx == SCAN_LAST) state_next = ST_PICK;
      ST_PICK: state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs and result values.
  always_comb begin
    cnt_we          = 1'b0;
    clear_all       = 1'b0;
    scan_start      = 1'b0;
    scan_step       = 1'b0;
    res_load        = 1'b0;
    out_load        = 1'b0;
    res_cpu_next    = it_cpu;
    res_queued_next = it_queued;
    res_err_next    = 1'b0;
    unique case (state)
      ST_EXEC: begin
        unique case (it_func)
          FUNC_ENQ: begin
            res_load = 1'b1;
            if (cfg_enable && it_worker) begin
              res_queued_next = 1'b1;
              if (it_in_range) begin
                cnt_we       = !at_limit;
                res_err_next = at_limit;
              end
            end
          end
          FUNC_DEQ: begin
            res_load = 1'b1;
            if (it_queued) begin
              res_queued_next = 1'b0;
              if (it_worker && it_in_range) begin
                cnt_we       = !at_limit;
                res_err_next = at_limit;
              end
            end
          end
          FUNC_FIND: begin
            if (scan_go) begin
              scan_start = 1'b1;
            end else begin
              res_load = 1'b1;
            end
          end
          FUNC_CLEAR: begin
            clear_all = 1'b1;
            res_load  = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SCAN: scan_step = 1'b1;
      ST_PICK: begin
        res_load = 1'b1;
        // Keep the proposed CPU when nothing qualified, or when it lies at or
        // above the middle start and the busiest candidate holds no worker.
        if (found && !((it_cpu >= cfg_start[2:0]) && (best_cnt == '0))) begin
          res_cpu_next = best_cpu;
        end
      end
      ST_DONE: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan position and the best candidate so far; the lowest CPU wins a tie.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (scan_start) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (scan_step) begin
      idx <= idx + 1'b1;
      if (scan_cand && (!found || cnt_greater)) begin
        found    <= 1'b1;
        best_cnt <= rd_cnt;
        best_cpu <= scan_cpu;
      end
    end
  end

  // Counter bank update.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        worker_count[i] <= '0;
      end
    end else if (cnt_we) begin
      worker_count[it_idx] <= cnt_step;
    end
  end

  // Result register, filled once the item's work is finished.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_cpu    <= res_cpu_next;
      res_queued <= res_queued_next;
      res_err    <= res_err_next;
    end
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cpu    <= res_cpu;
      out_queued <= res_queued;
      out_err    <= res_err;
    end
  end

  assign m_tdata = {3'b000, out_err, out_queued, out_cpu};

`ifndef SYNTH
  // An accepted item blocks the input until its result is handed off.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("input still ready after an item was accepted");

  // A picked CPU is always a member of the middle group and available.
  a_pick_in_group: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && found) |-> (cfg_group[best_cpu] && cfg_avail[best_cpu]))
    else $error("scan picked a CPU outside the available middle group");

  // A new result appears only as the hand-off from the finishing state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result valid raised outside the hand-off state");
`endif

endmodule
